### hw/rtl/midi_voice_allocator_envelope_macros.svh
// Assertion macros shared by the voice allocator checker.
// Both expect signals named clk and rst_n in the scope of use.
`ifndef MIDI_VOICE_ALLOCATOR_ENVELOPE_MACROS_SVH
`define MIDI_VOICE_ALLOCATOR_ENVELOPE_MACROS_SVH

// same-cycle implication
`define MVAE_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("voice allocator check failed");

// next-cycle implication
`define MVAE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("voice allocator check failed");

`endif

### hw/rtl/mvae_pkg.sv
// Package for the MIDI voice allocator: request/result structs, codes,
// register reset values and the envelope target function. No dependencies.
package mvae_pkg;

  localparam int VOICES_DEF = 8;
  localparam int MAX_REPORT = 8;
  localparam int RATE_W     = 10;
  localparam int DT_W       = 10;
  localparam int STEP_W     = 20;
  localparam int LEVEL_W    = 11;
  localparam int NOTE_W     = 7;
  localparam int CFG_IDX_W  = 2;

  localparam logic [2:0] KIND_NOTE_ON  = 3'd0;
  localparam logic [2:0] KIND_NOTE_OFF = 3'd1;
  localparam logic [2:0] KIND_CC       = 3'd2;
  localparam logic [2:0] KIND_RESET    = 3'd3;
  localparam logic [2:0] KIND_TICK     = 3'd4;

  localparam logic [6:0] CC_SUSTAIN    = 7'd64;
  localparam logic [6:0] CC_SOUND_OFF  = 7'd120;
  localparam logic [6:0] CC_NOTES_OFF  = 7'd123;
  localparam logic [6:0] PEDAL_THRESH  = 7'd64;

  localparam logic [CFG_IDX_W-1:0] REG_ATTACK      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RELEASE     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_ELAPSED = 2'd2;

  localparam logic [RATE_W-1:0] ATTACK_RST      = 10'd12;
  localparam logic [RATE_W-1:0] RELEASE_RST     = 10'd2;
  localparam logic [DT_W-1:0]   MAX_ELAPSED_RST = 10'd100;

  localparam logic [7:0]         NO_NOTE    = 8'd255;
  localparam logic [3:0]         COUNT_SAT  = 4'd15;
  localparam logic [LEVEL_W-1:0] LEVEL_ONE  = 11'd1;
  localparam logic [LEVEL_W-1:0] LEVEL_FULL = 11'd1024;

  typedef struct packed {
    logic [2:0]  kind;
    logic [6:0]  first_data;
    logic [6:0]  second_data;
    logic [15:0] elapsed_ms;
  } in_item_t;

  typedef struct packed {
    logic [2:0]         voice_index;
    logic [6:0]         voice_note;
    logic [LEVEL_W-1:0] voice_level;
    logic               voice_held;
    logic [3:0]         voices_sounding;
    logic [7:0]         lowest_note;
    logic               last;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_APPLY,
    ST_MUL,
    ST_UPDATE,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic en;
    logic sel_rel;
  } mul_ctrl_t;

  // vel*1024/127 = 8*vel + (8*vel)/127, the latter via >>7 and one correction
  function automatic logic [LEVEL_W-1:0] target_level(input logic [6:0] vel);
    logic [9:0] y;
    logic [3:0] q;
    logic [7:0] r;
    y = {vel, 3'b000};
    q = {1'b0, y[9:7]};
    r = {1'b0, y[6:0]} + {4'b0, q};
    if (r >= 8'd127) q = q + 4'd1;
    return {1'b0, y} + {7'b0, q};
  endfunction

endpackage

### hw/rtl/midi_voice_allocator_envelope.sv
// Voice allocator: a note-on/off is accepted, scans the voice table and makes one write;
// control change and reset finish on acceptance. A tick is accepted, runs the attack and
// release multiplier phases, updates every voice in turn and then emits one result a cycle
// unless stalled, for up to MAX_REPORT voices. One voice table read port sets this order.
// Synchronous active-low reset clears the voice table and pedal at once and
// loads the register reset values; no clearing pass.
module midi_voice_allocator_envelope #(
  parameter int VOICES = mvae_pkg::VOICES_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  mvae_pkg::in_item_t                in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output mvae_pkg::out_item_t               out_data,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [mvae_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [mvae_pkg::RATE_W-1:0]       cfg_data
);

  localparam int VIDX_W   = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int REPORTED = (VOICES < mvae_pkg::MAX_REPORT) ? VOICES : mvae_pkg::MAX_REPORT;
  localparam logic [VIDX_W-1:0] LAST_V = VIDX_W'(VOICES - 1);
  localparam logic [VIDX_W-1:0] LAST_R = VIDX_W'(REPORTED - 1);
  localparam int LW = mvae_pkg::LEVEL_W;

  mvae_pkg::state_t state_r, state_nxt;

  logic [VIDX_W-1:0]  idx_r;
  logic               mul_ph_r;
  logic [2:0]         kind_r;
  logic [6:0]         d1_r;
  logic [6:0]         d2_r;
  logic [mvae_pkg::DT_W-1:0] dt_r;

  logic [6:0]         note_r  [VOICES];
  logic [6:0]         vel_r   [VOICES];
  logic [LW-1:0]      level_r [VOICES];
  logic [VOICES-1:0]  held_r;
  logic [VOICES-1:0]  pend_r;
  logic               pedal_r;

  logic [mvae_pkg::RATE_W-1:0] attack_r;
  logic [mvae_pkg::RATE_W-1:0] release_r;
  logic [mvae_pkg::DT_W-1:0]   max_el_r;

  // scan results
  logic               found_r, sil_r, rel_r;
  logic [VIDX_W-1:0]  found_idx_r, sil_idx_r, rel_idx_r, all_idx_r;
  logic [LW-1:0]      rel_lvl_r, all_lvl_r;

  logic [3:0]         count_r;
  logic [7:0]         lowest_r;

  logic                 out_valid_r;
  mvae_pkg::out_item_t  out_data_r;

  logic                 in_acc;
  logic                 emit_load;
  logic                 is_pedal_up;
  mvae_pkg::mul_ctrl_t  mul_ctrl;
  logic [LW-1:0]        cur_lvl;
  logic [6:0]           cur_note;
  logic [LW-1:0]        lvl_nxt;
  logic [VIDX_W-1:0]    claim_idx;
  logic [mvae_pkg::DT_W-1:0] dt_in;

  assign in_acc    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign cur_lvl   = level_r[idx_r];
  assign cur_note  = note_r[idx_r];
  assign dt_in     = (in_data.elapsed_ms > {6'b0, max_el_r}) ? max_el_r
                                                            : in_data.elapsed_ms[9:0];
  assign is_pedal_up = pedal_r && (in_data.second_data < mvae_pkg::PEDAL_THRESH);

  always_comb begin
    if (found_r)    claim_idx = found_idx_r;
    else if (sil_r) claim_idx = sil_idx_r;
    else if (rel_r) claim_idx = rel_idx_r;
    else            claim_idx = all_idx_r;
  end

  mvae_env u_env (
    .clk          (clk),
    .mul_ctrl     (mul_ctrl),
    .dt           (dt_r),
    .attack_rate  (attack_r),
    .release_rate (release_r),
    .level        (cur_lvl),
    .velocity     (vel_r[idx_r]),
    .held         (held_r[idx_r]),
    .level_nxt    (lvl_nxt)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      mvae_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (in_data.kind == mvae_pkg::KIND_NOTE_ON ||
              in_data.kind == mvae_pkg::KIND_NOTE_OFF) state_nxt = mvae_pkg::ST_SCAN;
          else if (in_data.kind == mvae_pkg::KIND_TICK) state_nxt = mvae_pkg::ST_MUL;
        end
      end
      mvae_pkg::ST_SCAN:   if (idx_r == LAST_V) state_nxt = mvae_pkg::ST_APPLY;
      mvae_pkg::ST_APPLY:  state_nxt = mvae_pkg::ST_IDLE;
      mvae_pkg::ST_MUL:    if (mul_ph_r) state_nxt = mvae_pkg::ST_UPDATE;
      mvae_pkg::ST_UPDATE: if (idx_r == LAST_V) state_nxt = mvae_pkg::ST_EMIT;
      mvae_pkg::ST_EMIT:   if (emit_load && idx_r == LAST_R) state_nxt = mvae_pkg::ST_IDLE;
      default:             state_nxt = mvae_pkg::ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_stall         = (state_r != mvae_pkg::ST_IDLE);
    mul_ctrl.en      = (state_r == mvae_pkg::ST_MUL);
    mul_ctrl.sel_rel = mul_ph_r;
    emit_load        = (state_r == mvae_pkg::ST_EMIT) && (!out_valid_r || !out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mvae_pkg::ST_IDLE;
      idx_r       <= '0;
      mul_ph_r    <= 1'b0;
      kind_r      <= '0;
      d1_r        <= '0;
      d2_r        <= '0;
      dt_r        <= '0;
      held_r      <= '0;
      pend_r      <= '0;
      pedal_r     <= 1'b0;
      attack_r    <= mvae_pkg::ATTACK_RST;
      release_r   <= mvae_pkg::RELEASE_RST;
      max_el_r    <= mvae_pkg::MAX_ELAPSED_RST;
      found_r     <= 1'b0;
      sil_r       <= 1'b0;
      rel_r       <= 1'b0;
      found_idx_r <= '0;
      sil_idx_r   <= '0;
      rel_idx_r   <= '0;
      all_idx_r   <= '0;
      rel_lvl_r   <= '0;
      all_lvl_r   <= '0;
      count_r     <= '0;
      lowest_r    <= mvae_pkg::NO_NOTE;
      out_valid_r <= 1'b0;
      out_data_r  <= '0;
      for (int i = 0; i < VOICES; i++) begin
        note_r[i]  <= '0;
        vel_r[i]   <= '0;
        level_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;

      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          mvae_pkg::REG_ATTACK:      attack_r  <= cfg_data;
          mvae_pkg::REG_RELEASE:     release_r <= cfg_data;
          mvae_pkg::REG_MAX_ELAPSED: max_el_r  <= cfg_data;
          default: ;
        endcase
      end

      if (emit_load) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;

      unique case (state_r)
        mvae_pkg::ST_IDLE: begin
          idx_r <= '0;
          if (in_acc) begin
            kind_r   <= in_data.kind;
            d1_r     <= in_data.first_data;
            d2_r     <= in_data.second_data;
            dt_r     <= dt_in;
            found_r  <= 1'b0;
            sil_r    <= 1'b0;
            rel_r    <= 1'b0;
            count_r  <= '0;
            lowest_r <= mvae_pkg::NO_NOTE;
            if (in_data.kind == mvae_pkg::KIND_CC) begin
              if (in_data.first_data == mvae_pkg::CC_SUSTAIN) begin
                if (is_pedal_up) begin
                  held_r <= held_r & ~pend_r;
                  pend_r <= '0;
                end
                pedal_r <= (in_data.second_data >= mvae_pkg::PEDAL_THRESH);
              end else if (in_data.first_data == mvae_pkg::CC_SOUND_OFF ||
                           in_data.first_data == mvae_pkg::CC_NOTES_OFF) begin
                held_r  <= '0;
                pend_r  <= '0;
                pedal_r <= 1'b0;
              end
            end else if (in_data.kind == mvae_pkg::KIND_RESET) begin
              held_r  <= '0;
              pend_r  <= '0;
              pedal_r <= 1'b0;
            end
          end
        end

        mvae_pkg::ST_SCAN: begin
          idx_r <= (idx_r == LAST_V) ? '0 : idx_r + 1'b1;
          if (!found_r && cur_lvl != '0 && cur_note == d1_r) begin
            found_r     <= 1'b1;
            found_idx_r <= idx_r;
          end
          if (!sil_r && cur_lvl == '0) begin
            sil_r     <= 1'b1;
            sil_idx_r <= idx_r;
          end
          // quietest released voice, ties to the lowest index
          if (cur_lvl != '0 && !held_r[idx_r] && (!rel_r || cur_lvl < rel_lvl_r)) begin
            rel_r     <= 1'b1;
            rel_idx_r <= idx_r;
            rel_lvl_r <= cur_lvl;
          end
          if (idx_r == '0 || cur_lvl < all_lvl_r) begin
            all_idx_r <= idx_r;
            all_lvl_r <= cur_lvl;
          end
        end

        mvae_pkg::ST_APPLY: begin
          if (kind_r == mvae_pkg::KIND_NOTE_ON && d2_r != '0) begin
            note_r[claim_idx] <= d1_r;
            vel_r[claim_idx]  <= d2_r;
            pend_r[claim_idx] <= 1'b0;
            held_r[claim_idx] <= 1'b1;
            if (!found_r && sil_r) level_r[claim_idx] <= mvae_pkg::LEVEL_ONE;
          end else if (found_r) begin
            // velocity-zero note-on ignores the pedal
            if (kind_r == mvae_pkg::KIND_NOTE_OFF && pedal_r) pend_r[found_idx_r] <= 1'b1;
            else                                              held_r[found_idx_r] <= 1'b0;
          end
        end

        mvae_pkg::ST_MUL: begin
          mul_ph_r <= !mul_ph_r;
        end

        mvae_pkg::ST_UPDATE: begin
          idx_r          <= (idx_r == LAST_V) ? '0 : idx_r + 1'b1;
          level_r[idx_r] <= lvl_nxt;
          if (lvl_nxt != '0) begin
            if (count_r != mvae_pkg::COUNT_SAT) count_r <= count_r + 4'd1;
            if ({1'b0, cur_note} < lowest_r) lowest_r <= {1'b0, cur_note};
          end
        end

        mvae_pkg::ST_EMIT: begin
          if (emit_load) begin
            idx_r                      <= (idx_r == LAST_R) ? '0 : idx_r + 1'b1;
            out_data_r.voice_index     <= 3'(idx_r);
            out_data_r.voice_note      <= cur_note;
            out_data_r.voice_level     <= cur_lvl;
            out_data_r.voice_held      <= held_r[idx_r];
            out_data_r.voices_sounding <= count_r;
            out_data_r.lowest_note     <= lowest_r;
            out_data_r.last            <= (idx_r == LAST_R);
          end
        end

        default: ;
      endcase
    end
  end

endmodule

### hw/rtl/mvae_env.sv
// Envelope unit: shared rate multiplier (attack and release steps in turn)
// and the per-voice level update. Depends on mvae_pkg.
module mvae_env (
  input  logic                          clk,
  input  mvae_pkg::mul_ctrl_t           mul_ctrl,
  input  logic [mvae_pkg::DT_W-1:0]     dt,
  input  logic [mvae_pkg::RATE_W-1:0]   attack_rate,
  input  logic [mvae_pkg::RATE_W-1:0]   release_rate,
  input  logic [mvae_pkg::LEVEL_W-1:0]  level,
  input  logic [6:0]                    velocity,
  input  logic                          held,
  output logic [mvae_pkg::LEVEL_W-1:0]  level_nxt
);

  logic [mvae_pkg::STEP_W-1:0]    prod;
  logic [mvae_pkg::STEP_W-1:0]    step_att_r;
  logic [mvae_pkg::STEP_W-1:0]    step_rel_r;
  logic [mvae_pkg::STEP_W:0]      sum;
  logic [mvae_pkg::LEVEL_W-1:0]   tgt;

  assign prod = dt * (mul_ctrl.sel_rel ? release_rate : attack_rate);

  always_ff @(posedge clk) begin
    if (mul_ctrl.en) begin
      if (mul_ctrl.sel_rel) step_rel_r <= prod;
      else                  step_att_r <= prod;
    end
  end

  assign sum = {10'b0, level} + {1'b0, step_att_r};
  assign tgt = mvae_pkg::target_level(velocity);

  always_comb begin
    if (held) begin
      level_nxt = (sum < {10'b0, tgt}) ? sum[mvae_pkg::LEVEL_W-1:0] : tgt;
    end else if ({9'b0, level} > step_rel_r) begin
      level_nxt = level - step_rel_r[mvae_pkg::LEVEL_W-1:0];
    end else begin
      level_nxt = '0;
    end
  end

endmodule

### hw/rtl/mvae_checker.sv
// Port-level checks for the voice allocator, bound to the top level.
// Depends on mvae_pkg and midi_voice_allocator_envelope_macros.svh.
`include "midi_voice_allocator_envelope_macros.svh"

module mvae_checker (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_stall,
  input mvae_pkg::in_item_t   in_data,
  input logic                 out_valid,
  input logic                 out_stall,
  input mvae_pkg::out_item_t  out_data
);

  logic busy_req;
  logic count_zero;
  logic lowest_none;

  assign busy_req    = in_valid && !in_stall &&
                       (in_data.kind == mvae_pkg::KIND_NOTE_ON ||
                        in_data.kind == mvae_pkg::KIND_NOTE_OFF ||
                        in_data.kind == mvae_pkg::KIND_TICK);
  assign count_zero  = (out_data.voices_sounding == 4'd0);
  assign lowest_none = (out_data.lowest_note == mvae_pkg::NO_NOTE);

  // an accepted note or tick request always stalls the input in the following cycle
  `MVAE_ASSERT_NEXT(a_busy_after_item, busy_req, in_stall)
  `MVAE_ASSERT_NOW(a_count_vs_lowest, out_valid, count_zero == lowest_none)
  `MVAE_ASSERT_NOW(a_level_bound, out_valid, out_data.voice_level <= mvae_pkg::LEVEL_FULL)
  `MVAE_ASSERT_NEXT(a_hold_stalled, out_valid && out_stall, out_valid && $stable(out_data))

endmodule

bind midi_voice_allocator_envelope mvae_checker u_mvae_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

### bench/midi_voice_allocator_envelope_test.sv
// Self-checking bench for midi_voice_allocator_envelope: drives MIDI requests and register writes, predicts
// the per-voice tick reports with an in-bench voice table and compares them field by field.
// Depends on mvae_pkg and the block's RTL only.
`timescale 1ns / 1ps

module midi_voice_allocator_envelope_test;

  localparam int VOICES       = mvae_pkg::VOICES_DEF;
  localparam int QUIET_CYCLES = 32;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int IDLE_PCT     = 27;

  // codes with no name in the package
  localparam logic [mvae_pkg::CFG_IDX_W-1:0] REG_SPARE = 2'd3;
  localparam logic [2:0] KIND_SPARE_LO = 3'd5;
  localparam logic [2:0] KIND_SPARE_HI = 3'd7;
  localparam logic [6:0] CC_VOLUME     = 7'd7;

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           in_valid = 1'b0;
  logic                           in_stall;
  mvae_pkg::in_item_t             in_data = '0;
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  mvae_pkg::out_item_t            out_data;
  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [mvae_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [mvae_pkg::RATE_W-1:0]    cfg_data = '0;

  midi_voice_allocator_envelope dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #4 clk = ~clk;

  // voice table as the bench sees it
  logic [6:0]  note_tab [VOICES];
  logic [6:0]  vel_tab  [VOICES];
  bit          held     [VOICES];
  bit          pend     [VOICES];
  int unsigned lvl      [VOICES];
  bit          pedal;
  int unsigned attack_per_ms = mvae_pkg::ATTACK_RST;
  int unsigned decay_per_ms  = mvae_pkg::RELEASE_RST;
  int unsigned dt_cap        = mvae_pkg::MAX_ELAPSED_RST;

  mvae_pkg::out_item_t expected_reports [$];
  int          mismatches = 0;
  bit          steady_flow = 1'b0;
  int unsigned cycle_count = 0;

  initial begin
    for (int i = 0; i < VOICES; i++) begin
      note_tab[i] = '0;
      vel_tab[i]  = '0;
      held[i]     = 1'b0;
      pend[i]     = 1'b0;
      lvl[i]      = 0;
    end
    pedal = 1'b0;
  end

  function automatic int find_sounding(logic [6:0] note);
    for (int i = 0; i < VOICES; i++)
      if (lvl[i] != 0 && note_tab[i] == note) return i;
    return -1;
  endfunction

  // silent voice first, then quietest released, then quietest held; ties to lowest index
  function automatic int pick_voice();
    int best;
    best = -1;
    for (int i = 0; i < VOICES; i++) begin
      if (lvl[i] == 0) return i;
      if (!held[i] && (best < 0 || lvl[i] < lvl[best])) best = i;
    end
    if (best >= 0) return best;
    best = 0;
    for (int i = 1; i < VOICES; i++)
      if (lvl[i] < lvl[best]) best = i;
    return best;
  endfunction

  function automatic void release_every_voice();
    for (int i = 0; i < VOICES; i++) begin
      held[i] = 1'b0;
      pend[i] = 1'b0;
    end
    pedal = 1'b0;
  endfunction

  function automatic void advance_voices(mvae_pkg::in_item_t r);
    int                  v;
    int unsigned         dt, goal, stepv, sum, sounding;
    logic [7:0]          lowest;
    bit                  down;
    mvae_pkg::out_item_t e;
    case (r.kind)
      mvae_pkg::KIND_NOTE_ON: begin
        v = find_sounding(r.first_data);
        if (r.second_data == 0) begin
          if (v >= 0) held[v] = 1'b0;
        end else begin
          if (v < 0) v = pick_voice();
          note_tab[v] = r.first_data;
          vel_tab[v]  = r.second_data;
          pend[v]     = 1'b0;
          held[v]     = 1'b1;
          if (lvl[v] == 0) lvl[v] = 1;
        end
      end
      mvae_pkg::KIND_NOTE_OFF: begin
        v = find_sounding(r.first_data);
        if (v >= 0) begin
          if (!pedal) held[v] = 1'b0;
          else pend[v] = 1'b1;
        end
      end
      mvae_pkg::KIND_CC: begin
        if (r.first_data == mvae_pkg::CC_SUSTAIN) begin
          down = r.second_data >= mvae_pkg::PEDAL_THRESH;
          if (pedal && !down) begin
            for (int i = 0; i < VOICES; i++)
              if (pend[i]) begin
                pend[i] = 1'b0;
                held[i] = 1'b0;
              end
          end
          pedal = down;
        end else if (r.first_data == mvae_pkg::CC_SOUND_OFF ||
                     r.first_data == mvae_pkg::CC_NOTES_OFF) begin
          release_every_voice();
        end
      end
      mvae_pkg::KIND_RESET: release_every_voice();
      mvae_pkg::KIND_TICK: begin
        dt = (r.elapsed_ms > dt_cap) ? dt_cap : 32'(r.elapsed_ms);
        sounding = 0;
        lowest = mvae_pkg::NO_NOTE;
        for (int i = 0; i < VOICES; i++) begin
          if (held[i]) begin
            goal  = 32'(vel_tab[i]) * 1024 / 127;
            stepv = dt * attack_per_ms;
            sum   = lvl[i] + stepv;
            lvl[i] = (sum < goal) ? sum : goal;
          end else if (lvl[i] != 0) begin
            stepv = dt * decay_per_ms;
            lvl[i] = (lvl[i] > stepv) ? lvl[i] - stepv : 0;
          end
          if (lvl[i] != 0) begin
            sounding++;
            if ({1'b0, note_tab[i]} < lowest) lowest = {1'b0, note_tab[i]};
          end
        end
        if (sounding > mvae_pkg::COUNT_SAT) sounding = 32'(mvae_pkg::COUNT_SAT);
        for (int i = 0; i < VOICES && i < mvae_pkg::MAX_REPORT; i++) begin
          e.voice_index     = 3'(i);
          e.voice_note      = note_tab[i];
          e.voice_level     = mvae_pkg::LEVEL_W'(lvl[i]);
          e.voice_held      = held[i];
          e.voices_sounding = 4'(sounding);
          e.lowest_note     = lowest;
          e.last            = (i == VOICES - 1 || i == mvae_pkg::MAX_REPORT - 1);
          expected_reports.push_back(e);
        end
      end
      default: ;
    endcase
  endfunction

  function automatic void apply_register(logic [mvae_pkg::CFG_IDX_W-1:0] idx,
                                         logic [mvae_pkg::RATE_W-1:0] val);
    case (idx)
      mvae_pkg::REG_ATTACK:      attack_per_ms = 32'(val);
      mvae_pkg::REG_RELEASE:     decay_per_ms = 32'(val);
      mvae_pkg::REG_MAX_ELAPSED: dt_cap = 32'(val);
      default: ;
    endcase
  endfunction

  function automatic bit request_ignored(mvae_pkg::in_item_t r);
    if (r.kind > mvae_pkg::KIND_TICK) return 1'b1;
    if (r.kind == mvae_pkg::KIND_CC && r.first_data != mvae_pkg::CC_SUSTAIN &&
        r.first_data != mvae_pkg::CC_SOUND_OFF &&
        r.first_data != mvae_pkg::CC_NOTES_OFF) return 1'b1;
    return 1'b0;
  endfunction

  function automatic void check_field(string field, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      mismatches++;
    end
  endfunction

  // result side: compare on acceptance, then pick the stall for the next edge
  always @(posedge clk) begin : report_check
    mvae_pkg::out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_reports.size() == 0) begin
        $error("voice report with none pending: voice_index %0d", out_data.voice_index);
        mismatches++;
      end else begin
        want = expected_reports.pop_front();
        check_field("voice_index", 16'(want.voice_index), 16'(out_data.voice_index));
        check_field("voice_note", 16'(want.voice_note), 16'(out_data.voice_note));
        check_field("voice_level", 16'(want.voice_level), 16'(out_data.voice_level));
        check_field("voice_held", 16'(want.voice_held), 16'(out_data.voice_held));
        check_field("voices_sounding", 16'(want.voices_sounding),
                    16'(out_data.voices_sounding));
        check_field("lowest_note", 16'(want.lowest_note), 16'(out_data.lowest_note));
        check_field("last", 16'(want.last), 16'(out_data.last));
      end
    end
    out_stall <= !steady_flow && ($urandom_range(0, 99) < IDLE_PCT);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL midi_voice_allocator_envelope");
      $finish;
    end
  end

  task automatic send_request(input logic [2:0] kind, input logic [6:0] d1,
                              input logic [6:0] d2, input logic [15:0] el);
    mvae_pkg::in_item_t r;
    r.kind = kind;
    r.first_data = d1;
    r.second_data = d2;
    r.elapsed_ms = el;
    while (!steady_flow && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= r;
    do @(posedge clk); while (in_stall);
    advance_voices(r);
  endtask

  // drain all reports and let a trailing note or controller request finish
  task automatic settle();
    in_valid <= 1'b0;
    while (expected_reports.size() != 0) @(posedge clk);
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  task automatic set_registers(input logic [mvae_pkg::RATE_W-1:0] atk,
                               input logic [mvae_pkg::RATE_W-1:0] dcy,
                               input logic [mvae_pkg::RATE_W-1:0] cap, input bit with_spare);
    logic [mvae_pkg::CFG_IDX_W-1:0] idx [4];
    logic [mvae_pkg::RATE_W-1:0]    val [4];
    idx = '{mvae_pkg::REG_ATTACK, mvae_pkg::REG_RELEASE, mvae_pkg::REG_MAX_ELAPSED, REG_SPARE};
    val = '{atk, dcy, cap, mvae_pkg::RATE_W'($urandom)};
    settle();
    for (int k = 0; k < (with_spare ? 4 : 3); k++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[k];
      cfg_data  <= val[k];
      do @(posedge clk); while (!cfg_ready);
      apply_register(idx[k], val[k]);
    end
    cfg_valid <= 1'b0;
  endtask

  // mostly playable traffic, with some noise of any kind
  task automatic send_random_request(output bit counted);
    mvae_pkg::in_item_t r;
    int                 pick;
    r.kind        = mvae_pkg::KIND_NOTE_ON;
    r.first_data  = 7'($urandom);
    r.second_data = 7'($urandom);
    r.elapsed_ms  = 16'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 35) begin
      if ($urandom_range(0, 3) != 0) r.first_data = 7'($urandom_range(48, 63));
      r.second_data = ($urandom_range(0, 19) == 0) ? 7'd0 : 7'($urandom_range(1, 127));
    end else if (pick < 55) begin
      r.kind = mvae_pkg::KIND_NOTE_OFF;
      if ($urandom_range(0, 4) != 0) r.first_data = note_tab[$urandom_range(0, VOICES - 1)];
    end else if (pick < 75) begin
      r.kind = mvae_pkg::KIND_TICK;
      if ($urandom_range(0, 4) != 0) r.elapsed_ms = 16'($urandom_range(0, 40));
    end else if (pick < 85) begin
      r.kind = mvae_pkg::KIND_CC;
      r.first_data = mvae_pkg::CC_SUSTAIN;
    end else if (pick < 89) begin
      r.kind = mvae_pkg::KIND_CC;
      r.first_data = $urandom_range(0, 1) ? mvae_pkg::CC_SOUND_OFF : mvae_pkg::CC_NOTES_OFF;
    end else if (pick < 92) begin
      r.kind = mvae_pkg::KIND_RESET;
    end else begin
      r.kind = 3'($urandom);
    end
    send_request(r.kind, r.first_data, r.second_data, r.elapsed_ms);
    counted = !request_ignored(r);
  endtask

  task automatic run_traffic(input int count);
    int done;
    bit counted;
    done = 0;
    while (done < count) begin
      send_random_request(counted);
      if (counted) done++;
    end
  endtask

  task automatic test_directed_events();
    send_request(mvae_pkg::KIND_NOTE_ON, 7'd0, 7'd127, 16'($urandom));
    send_request(mvae_pkg::KIND_NOTE_ON, 7'd127, 7'd1, 16'($urandom));
    send_request(mvae_pkg::KIND_TICK, 7'($urandom), 7'($urandom), 16'd0);
    send_request(mvae_pkg::KIND_TICK, 7'($urandom), 7'($urandom), 16'hFFFF);
    // same note again: held level now above its new, lower target
    send_request(mvae_pkg::KIND_NOTE_ON, 7'd0, 7'd64, 16'($urandom));
    send_request(mvae_pkg::KIND_TICK, 7'($urandom), 7'($urandom), 16'd1);
    send_request(mvae_pkg::KIND_NOTE_ON, 7'd127, 7'd0, 16'($urandom));
    send_request(mvae_pkg::KIND_NOTE_OFF, 7'd55, 7'($urandom), 16'($urandom));
    send_request(mvae_pkg::KIND_CC, mvae_pkg::CC_SUSTAIN, mvae_pkg::PEDAL_THRESH,
                 16'($urandom));
    send_request(mvae_pkg::KIND_NOTE_OFF, 7'd0, 7'($urandom), 16'($urandom));
    // zero velocity ignores the pedal
    send_request(mvae_pkg::KIND_NOTE_ON, 7'd30, 7'd90, 16'($urandom));
    send_request(mvae_pkg::KIND_NOTE_ON, 7'd30, 7'd0, 16'($urandom));
    send_request(mvae_pkg::KIND_TICK, 7'($urandom), 7'($urandom), 16'd5);
    send_request(mvae_pkg::KIND_CC, mvae_pkg::CC_SUSTAIN, mvae_pkg::PEDAL_THRESH - 7'd1,
                 16'($urandom));
    send_request(mvae_pkg::KIND_CC, CC_VOLUME, 7'd100, 16'($urandom));
    for (int k = KIND_SPARE_LO; k <= KIND_SPARE_HI; k++)
      send_request(3'(k), 7'($urandom), 7'($urandom), 16'($urandom));
    send_request(mvae_pkg::KIND_TICK, 7'($urandom), 7'($urandom), 16'd20);
    send_request(mvae_pkg::KIND_NOTE_ON, 7'd64, 7'd100, 16'($urandom));
    send_request(mvae_pkg::KIND_CC, mvae_pkg::CC_SOUND_OFF, 7'($urandom), 16'($urandom));
    send_request(mvae_pkg::KIND_TICK, 7'($urandom), 7'($urandom), 16'd3);
    send_request(mvae_pkg::KIND_NOTE_ON, 7'd65, 7'd100, 16'($urandom));
    send_request(mvae_pkg::KIND_CC, mvae_pkg::CC_NOTES_OFF, 7'($urandom), 16'($urandom));
    send_request(mvae_pkg::KIND_NOTE_ON, 7'd66, 7'd100, 16'($urandom));
    send_request(mvae_pkg::KIND_RESET, 7'($urandom), 7'($urandom), 16'($urandom));
    send_request(mvae_pkg::KIND_TICK, 7'($urandom), 7'($urandom), 16'hFFFF);
  endtask

  // fill every voice, then force stealing from released and from held voices
  task automatic test_voice_stealing();
    int base;
    base = $urandom_range(0, 100);
    steady_flow = 1'b1;
    for (int i = 0; i < VOICES; i++)
      send_request(mvae_pkg::KIND_NOTE_ON, 7'(base + i), 7'($urandom_range(1, 127)),
                   16'($urandom));
    send_request(mvae_pkg::KIND_TICK, 7'($urandom), 7'($urandom), 16'($urandom_range(1, 5)));
    for (int i = 0; i < 3; i++)
      send_request(mvae_pkg::KIND_NOTE_OFF, 7'(base + 2 * i + 1), 7'($urandom),
                   16'($urandom));
    send_request(mvae_pkg::KIND_TICK, 7'($urandom), 7'($urandom), 16'($urandom_range(1, 5)));
    for (int i = 0; i < 2; i++)
      send_request(mvae_pkg::KIND_NOTE_ON, 7'(base + 10 + i), 7'($urandom_range(1, 127)),
                   16'($urandom));
    send_request(mvae_pkg::KIND_TICK, 7'($urandom), 7'($urandom), 16'($urandom_range(1, 5)));
    for (int i = 0; i < 3; i++)
      send_request(mvae_pkg::KIND_NOTE_ON, 7'(base + 20 + i), 7'($urandom_range(1, 127)),
                   16'($urandom));
    send_request(mvae_pkg::KIND_TICK, 7'($urandom), 7'($urandom), 16'($urandom_range(1, 5)));
    steady_flow = 1'b0;
  endtask

  task automatic test_register_extremes();
    set_registers(10'd1023, 10'd1023, 10'd1023, 1'b1);
    run_traffic(10);
    set_registers(10'd0, 10'd0, 10'd0, 1'b0);
    run_traffic(10);
  endtask

  task automatic test_random_traffic();
    set_registers(mvae_pkg::ATTACK_RST, mvae_pkg::RELEASE_RST, mvae_pkg::MAX_ELAPSED_RST,
                  1'b0);
    steady_flow = 1'b1;
    run_traffic(30);
    steady_flow = 1'b0;
    set_registers(10'($urandom_range(1, 1023)), 10'($urandom_range(1, 1023)), 10'd1000, 1'b1);
    run_traffic(30);
    set_registers(10'($urandom_range(1, 60)), 10'($urandom_range(1, 20)),
                  10'($urandom_range(0, 1023)), 1'b0);
    run_traffic(30);
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_events();
    test_voice_stealing();
    test_register_extremes();
    test_random_traffic();
    settle();
    if (mismatches == 0 && expected_reports.size() == 0)
      $display("PASS midi_voice_allocator_envelope");
    else
      $display("FAIL midi_voice_allocator_envelope");
    $finish;
  end

endmodule

### filelist.f
+incdir+hw/rtl
hw/rtl/mvae_pkg.sv
hw/rtl/mvae_env.sv
hw/rtl/midi_voice_allocator_envelope.sv
hw/rtl/mvae_checker.sv
bench/midi_voice_allocator_envelope_test.sv
